### rtl/msp_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants for the minimum-tracking stack.
// -----------------------------------------------------------------------------
package msp_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    // Minimum seen by a push onto an empty stack
    localparam logic signed [DATA_W-1:0] EMPTY_MIN = 32'sh7FFF_FFFF;

    // Command codes; code 3 carries no meaning and falls to a default arm
    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // One stack entry: value and minimum of it and everything below
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] minimum;
    } t_entry;

    // Control bundle from the sequencer to the entry RAM
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

    // One result item
    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] current_min;
        logic                     now_empty;
        logic [1:0]               status;
    } t_result;

endpackage

### rtl/msp_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// msp_cmd_if / msp_res_if
// Valid/ready channels for stack commands and stack results.
// -----------------------------------------------------------------------------
interface msp_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface msp_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] top_value;
    logic signed [31:0] current_min;
    logic               now_empty;
    logic [1:0]         status;

    modport source (output valid, output top_value, output current_min,
                    output now_empty, output status, input ready);
    modport sink   (input valid, input top_value, input current_min,
                    input now_empty, input status, output ready);
endinterface

### rtl/msp_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// msp_ram
// Entry store: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module msp_ram
    import msp_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    input  t_entry   i_wr_data,
    output t_entry   o_rd_data
);

    t_entry r_mem [STACK_DEPTH];
    t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/min_stack_paired_entries.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// min_stack_paired_entries
// LIFO stack of signed 32-bit values that reports the running minimum.
//
//   Channel | Dir | Payload                                      | Transfer
//   i_cmd   | in  | command, push_value                          | valid & ready
//   o_res   | out | top_value, current_min, now_empty, status    | valid & ready
//
// Push, peek and errors register their result directly; a pop that leaves
// entries behind passes through the refill state, since the new top entry comes back registered from the entry RAM.
// The top entry is cached in flops; the RAM holds all entries by position.
// Reset (synchronous, active low) empties the stack; RAM contents are kept.
// A result waits in the output register; the next command is taken in the
// same cycle the waiting result transfers.
// -----------------------------------------------------------------------------
module min_stack_paired_entries
    import msp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    msp_cmd_if.sink      i_cmd,
    msp_res_if.source    o_res
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_REFILL = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [DATA_W-1:0] r_top_val, n_top_val;
    logic signed [DATA_W-1:0] r_top_min, n_top_min;
    logic signed [DATA_W-1:0] r_pop_val, n_pop_val;
    logic                     r_out_valid, n_out_valid;
    t_result                  r_out, n_out;

    t_ram_req                 w_req;
    t_entry                   w_wr_data;
    t_entry                   w_rd_data;

    logic                     w_accept;
    logic                     w_empty;
    logic                     w_full;
    logic signed [DATA_W-1:0] w_cur_min;
    logic signed [DATA_W-1:0] w_prev_min;
    logic signed [DATA_W-1:0] w_new_min;
    logic [CNT_W-1:0]         w_below_idx;

    msp_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    // Handshake and status of the stack; no transfer while in reset
    assign i_cmd.ready = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CNT_W'(STACK_DEPTH));
    assign w_cur_min   = w_empty ? '0 : r_top_min;

    // Running minimum for a push
    assign w_prev_min  = w_empty ? EMPTY_MIN : r_top_min;
    assign w_new_min   = (i_cmd.push_value < w_prev_min) ? i_cmd.push_value : w_prev_min;
    assign w_below_idx = r_count - CNT_W'(2);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top_val   = r_top_val;
        n_top_min   = r_top_min;
        n_pop_val   = r_pop_val;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        w_req       = '0;
        w_wr_data   = '{value: i_cmd.push_value, minimum: w_new_min};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_out       = '{top_value: '0, current_min: w_cur_min,
                                    now_empty: w_empty, status: ST_OK};
                    case (i_cmd.command)
                        CMD_PUSH: begin
                            if (w_full) begin
                                n_out.status = ST_OVERFLOW;
                            end else begin
                                w_req.wr_en       = 1'b1;
                                w_req.wr_addr     = r_count[ADDR_W-1:0];
                                n_top_val         = i_cmd.push_value;
                                n_top_min         = w_new_min;
                                n_count           = r_count + CNT_W'(1);
                                n_out.current_min = w_new_min;
                                n_out.now_empty   = 1'b0;
                            end
                        end
                        CMD_POP: begin
                            if (w_empty) begin
                                n_out.status = ST_UNDERFLOW;
                            end else if (r_count == CNT_W'(1)) begin
                                n_count           = '0;
                                n_out.top_value   = r_top_val;
                                n_out.current_min = '0;
                                n_out.now_empty   = 1'b1;
                            end else begin
                                // fetch the entry below; the refill state builds the result
                                n_count       = r_count - CNT_W'(1);
                                n_pop_val     = r_top_val;
                                w_req.rd_en   = 1'b1;
                                w_req.rd_addr = w_below_idx[ADDR_W-1:0];
                                n_out_valid   = 1'b0;
                                n_state       = S_REFILL;
                            end
                        end
                        CMD_PEEK: begin
                            if (w_empty) begin
                                n_out.status = ST_UNDERFLOW;
                            end else begin
                                n_out.top_value = r_top_val;
                            end
                        end
                        default: begin
                            // unused code: report unchanged stack
                        end
                    endcase
                end
            end
            S_REFILL: begin
                n_top_val   = w_rd_data.value;
                n_top_min   = w_rd_data.minimum;
                n_out_valid = 1'b1;
                n_out       = '{top_value: r_pop_val, current_min: w_rd_data.minimum,
                                now_empty: 1'b0, status: ST_OK};
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_top_val <= n_top_val;
        r_top_min <= n_top_min;
        r_pop_val <= n_pop_val;
        r_out     <= n_out;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.top_value   = r_out.top_value;
    assign o_res.current_min = r_out.current_min;
    assign o_res.now_empty   = r_out.now_empty;
    assign o_res.status      = r_out.status;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("fill count beyond stack depth");

    a_refill_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REFILL) |-> !r_out_valid)
        else $error("output register busy during refill");

    a_refill_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REFILL) |=> (r_state == S_IDLE) && r_out_valid)
        else $error("refill did not produce a result");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.command == CMD_PUSH) && !w_full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push did not advance fill count");

    a_refill_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REFILL) |-> (r_count != '0))
        else $error("refill with empty stack");

endmodule
